@@ hw/rtl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared codes, widths and the command type of the bitstream reader.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int BUF_W  = 64;
    localparam int CNT_W  = 7;
    localparam int SVAL_W = 33;

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_UEG   = 3'd3;
    localparam logic [2:0] OP_SEG   = 3'd4;
    localparam logic [2:0] OP_ALIGN = 3'd5;
    localparam logic [2:0] OP_FLUSH = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_PUSH   = 3'd1;
    localparam logic [2:0] K_TAKE   = 3'd2;
    localparam logic [2:0] K_GOLOMB = 3'd3;
    localparam logic [2:0] K_ALIGN  = 3'd4;
    localparam logic [2:0] K_FLUSH  = 3'd5;

    localparam logic [CNT_W-1:0] PUSH_LIMIT = 7'd56;

    typedef struct packed {
        logic [2:0]       kind;
        logic             consume;
        logic             sgn;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] bit_count;
    } t_cmd;

endpackage

@@ hw/rtl/bitstream_reader_exp_golomb.sv @@
// ----------------------------------------------------------------------------
// bitstream_reader_exp_golomb
// MSB-first bit reader over a 64-bit buffer with Exp-Golomb decoding.
//
// Input channel: i_valid / o_stall carry opcode, data_byte and bit_count.
// A transfer happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry value, signed_value, status and
// bits_held; one result per input item, in order.
// An accepted item is written into the command queue, then loaded from it into
// the result register.
// Throughput is one item per cycle when not stalled: the execution stage
// applies each command to the buffer (barrel shift plus 32-bit leading-zero
// count), and a two-entry command queue sits between decode and execution.
// When the receiver stalls, the result register holds its contents, the
// queue fills, and o_stall rises once both entries are taken.
// Reset empties the queue, drops any pending result and clears the buffer
// and bit count to zero.
// ----------------------------------------------------------------------------
module bitstream_reader_exp_golomb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_data_byte,
    input  logic [6:0]          i_bit_count,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [63:0]         o_value,
    output logic signed [32:0]  o_signed_value,
    output logic [1:0]          o_status,
    output logic [6:0]          o_bits_held
);

    bsr_pkg::t_cmd front_cmd;
    bsr_pkg::t_cmd q_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          in_xfer;

    assign o_stall = q_full;
    assign in_xfer = i_valid && !q_full;

    bsr_front u_front (
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .o_cmd       (front_cmd)
    );

    bsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    bsr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_pop      (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_signed_value (o_signed_value),
        .o_status       (o_status),
        .o_bits_held    (o_bits_held)
    );

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bits_held <= 7'd64))
        else $error("bits_held above buffer size");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bsr_pkg::ST_OK)) |->
            ((o_value == 64'd0) && (o_signed_value == 33'sd0)))
        else $error("failed item with non-zero result");

    a_full_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bsr_pkg::ST_FULL)) |->
            (o_bits_held > bsr_pkg::PUSH_LIMIT))
        else $error("push refused with room in buffer");

endmodule

@@ hw/rtl/bsr_front.sv @@
// ----------------------------------------------------------------------------
// bsr_front
// Classifies an incoming opcode into a command for the execution stage.
// ----------------------------------------------------------------------------
module bsr_front (
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_data_byte,
    input  logic [6:0]          i_bit_count,
    output bsr_pkg::t_cmd       o_cmd
);

    always_comb begin
        o_cmd.kind      = bsr_pkg::K_NOP;
        o_cmd.consume   = 1'b0;
        o_cmd.sgn       = 1'b0;
        o_cmd.data_byte = i_data_byte;
        o_cmd.bit_count = i_bit_count;
        case (i_opcode)
            bsr_pkg::OP_PUSH: begin
                o_cmd.kind = bsr_pkg::K_PUSH;
            end
            bsr_pkg::OP_READ: begin
                o_cmd.kind    = bsr_pkg::K_TAKE;
                o_cmd.consume = 1'b1;
            end
            bsr_pkg::OP_PEEK: begin
                o_cmd.kind = bsr_pkg::K_TAKE;
            end
            bsr_pkg::OP_UEG: begin
                o_cmd.kind    = bsr_pkg::K_GOLOMB;
                o_cmd.consume = 1'b1;
            end
            bsr_pkg::OP_SEG: begin
                o_cmd.kind    = bsr_pkg::K_GOLOMB;
                o_cmd.consume = 1'b1;
                o_cmd.sgn     = 1'b1;
            end
            bsr_pkg::OP_ALIGN: begin
                o_cmd.kind = bsr_pkg::K_ALIGN;
            end
            bsr_pkg::OP_FLUSH: begin
                o_cmd.kind = bsr_pkg::K_FLUSH;
            end
            default: begin
                o_cmd.kind = bsr_pkg::K_NOP;
            end
        endcase
    end

endmodule

@@ hw/rtl/bsr_queue.sv @@
// ----------------------------------------------------------------------------
// bsr_queue
// Two-entry command queue between the front end and the execution stage.
// ----------------------------------------------------------------------------
module bsr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bsr_pkg::t_cmd       i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output bsr_pkg::t_cmd       o_cmd,
    input  logic                i_pop
);

    bsr_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/bsr_back.sv @@
// ----------------------------------------------------------------------------
// bsr_back
// Holds the bit buffer, executes one command per cycle unless stalled, registers the result.
// ----------------------------------------------------------------------------
module bsr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  bsr_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [63:0]         o_value,
    output logic signed [32:0]  o_signed_value,
    output logic [1:0]          o_status,
    output logic [6:0]          o_bits_held
);

    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [31:0] v;
        logic [5:0]  n;
        v = x;
        n = 6'd0;
        if (x == 32'd0) begin
            n = 6'd32;
        end else begin
            if (v[31:16] == 16'd0) begin
                n = n + 6'd16;
                v = v << 16;
            end
            if (v[31:24] == 8'd0) begin
                n = n + 6'd8;
                v = v << 8;
            end
            if (v[31:28] == 4'd0) begin
                n = n + 6'd4;
                v = v << 4;
            end
            if (v[31:30] == 2'd0) begin
                n = n + 6'd2;
                v = v << 2;
            end
            if (v[31] == 1'b0) begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

    logic [bsr_pkg::BUF_W-1:0]  r_buf;
    logic [bsr_pkg::CNT_W-1:0]  r_held;
    logic [bsr_pkg::BUF_W-1:0]  n_buf;
    logic [bsr_pkg::CNT_W-1:0]  n_held;
    logic [63:0]                n_value;
    logic signed [32:0]         n_sval;
    logic [1:0]                 n_status;

    logic [63:0]                aligned;
    logic [5:0]                 lz;
    logic [6:0]                 g_len;
    logic                       g_long;
    logic                       g_short;
    logic [6:0]                 take_n;
    logic [6:0]                 rest;
    logic [63:0]                take_v;
    logic [63:0]                rest_mask;
    logic [6:0]                 align_held;
    logic [32:0]                mag;

    assign o_cmd_pop = i_cmd_valid && (!o_valid || !i_stall);

    always_comb begin
        aligned    = r_buf << (7'd64 - r_held);
        lz         = lzc32(aligned[63:32]);
        g_len      = {lz, 1'b1};
        g_long     = (lz == 6'd32) && (r_held >= 7'd32);
        g_short    = (g_len > r_held);
        take_n     = (i_cmd.kind == bsr_pkg::K_GOLOMB) ? g_len : i_cmd.bit_count;
        rest       = r_held - take_n;
        take_v     = (r_buf >> rest) & ((64'd1 << take_n) - 64'd1);
        rest_mask  = (64'd1 << rest) - 64'd1;
        align_held = {r_held[6:3], 3'b000};
        mag        = take_v[33:1];

        n_buf    = r_buf;
        n_held   = r_held;
        n_value  = 64'd0;
        n_sval   = 33'sd0;
        n_status = bsr_pkg::ST_OK;

        case (i_cmd.kind)
            bsr_pkg::K_PUSH: begin
                if (r_held > bsr_pkg::PUSH_LIMIT) begin
                    n_status = bsr_pkg::ST_FULL;
                end else begin
                    n_buf  = {r_buf[55:0], i_cmd.data_byte};
                    n_held = r_held + 7'd8;
                end
            end
            bsr_pkg::K_TAKE: begin
                if (i_cmd.bit_count > r_held) begin
                    n_status = bsr_pkg::ST_SHORT;
                end else begin
                    n_value = take_v;
                    if (i_cmd.consume) begin
                        n_buf  = r_buf & rest_mask;
                        n_held = rest;
                    end
                end
            end
            bsr_pkg::K_GOLOMB: begin
                if (g_long) begin
                    n_status = bsr_pkg::ST_LONG;
                end else if (g_short) begin
                    n_status = bsr_pkg::ST_SHORT;
                end else begin
                    n_buf  = r_buf & rest_mask;
                    n_held = rest;
                    if (i_cmd.sgn) begin
                        n_sval = take_v[0] ? -$signed(mag) : $signed(mag);
                    end else begin
                        n_value = take_v - 64'd1;
                    end
                end
            end
            bsr_pkg::K_ALIGN: begin
                n_held = align_held;
                n_buf  = r_buf & ((64'd1 << align_held) - 64'd1);
            end
            bsr_pkg::K_FLUSH: begin
                n_held = 7'd0;
                n_buf  = 64'd0;
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= 64'd0;
            r_held  <= 7'd0;
            o_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_buf   <= n_buf;
                r_held  <= n_held;
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            o_value        <= n_value;
            o_signed_value <= n_sval;
            o_status       <= n_status;
            o_bits_held    <= n_held;
        end
    end

endmodule
